### rtl/assert_macros.svh
// Assertion macros shared by the fractal noise RTL.
// Define NO_ASSERTIONS to compile every check away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset
`define FGNH_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fgnh assertion failed");
// Next-cycle implication, checked outside reset
`define FGNH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fgnh assertion failed");
`else
`define FGNH_ASSERT_IMPL(label, clk, rst, ante, cons)
`define FGNH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/fgnh_pkg.sv
// Shared constants, types and the gradient function of the fractal noise block.
// No dependencies; used by fgnh_octave and the top level.
package fgnh_pkg;

   localparam int OCTAVES   = 6;
   localparam int FRAC_BITS = 16;
   localparam int PERM_W    = 8;
   localparam int COORD_W   = FRAC_BITS + 8;
   localparam int NOISE_W   = FRAC_BITS + 3;   // per-octave noise, signed
   localparam int SUM_W     = NOISE_W + 3;     // raw octave sum, signed
   localparam int NSUM_W    = FRAC_BITS + 2;   // saturated sum, signed Q2.F
   localparam int HEIGHT_W  = FRAC_BITS + 7;   // height, unsigned Q7.F
   localparam int REG_W     = 16;

   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = HEIGHT_W'(100 << FRAC_BITS);

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_EVAL = 1'b1
   } action_type;

   typedef enum logic {
      CSR_HEIGHT_SCALE = 1'b0,
      CSR_BASE_HEIGHT  = 1'b1
   } csr_index_type;

   // Table write travelling beside the evaluate items
   typedef struct packed {
      logic              load;
      logic [PERM_W-1:0] idx;
      logic [PERM_W-1:0] val;
   } load_type;

   // Gradient dot product with z = 0
   function automatic logic signed [NOISE_W-1:0] grad_fn(
      input logic [3:0]                 h,
      input logic signed [FRAC_BITS+1:0] x,
      input logic signed [FRAC_BITS+1:0] y
   );
      logic signed [NOISE_W-1:0] u;
      logic signed [NOISE_W-1:0] v;
      u = (h < 4'd8) ? NOISE_W'(x) : NOISE_W'(y);
      if (h < 4'd4) begin
         v = NOISE_W'(y);
      end else if (h == 4'd12 || h == 4'd14) begin
         v = NOISE_W'(x);
      end else begin
         v = '0;
      end
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

endpackage

### rtl/fgnh_ram.sv
// Permutation table copy: 256 x 8, one write port, two registered read ports.
// No dependencies.
module fgnh_ram (
   input  logic       clock,
   input  logic       wr_en,
   input  logic [7:0] wr_addr,
   input  logic [7:0] wr_data,
   input  logic       rd_en,
   input  logic [7:0] rd_addr0,
   input  logic [7:0] rd_addr1,
   output logic [7:0] rd_data0,
   output logic [7:0] rd_data1
);

   logic [7:0] mem_ff [256];
   logic [7:0] rd0_ff;
   logic [7:0] rd1_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read two entries, hold on stall
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd0_ff <= mem_ff[rd_addr0];
         rd1_ff <= mem_ff[rd_addr1];
      end
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule

### rtl/fgnh_octave.sv
// One noise octave: three table copies, fade curves, gradients and lerps.
// Depends on fgnh_pkg and fgnh_ram; the pipeline holds while advance is low.
module fgnh_octave (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  fgnh_pkg::load_type                    ld,
   input  logic [fgnh_pkg::COORD_W-1:0]          coord_x,
   input  logic [fgnh_pkg::COORD_W-1:0]          coord_y,
   output logic signed [fgnh_pkg::NOISE_W-1:0]   noise
);

   localparam int F  = fgnh_pkg::FRAC_BITS;
   localparam int NW = fgnh_pkg::NOISE_W;
   localparam int PW = fgnh_pkg::PERM_W;

   logic [PW-1:0] xi, yi, pa0, pa1, hb0, hb1, hc0, hc1, a_idx, b_idx;
   logic [F-1:0]  xf, yf;

   // Stage 1
   fgnh_pkg::load_type ld1_ff;
   logic [PW-1:0] yi1_ff;
   logic [F-1:0]  xf1_ff, yf1_ff, t2x1_ff, t2y1_ff;
   logic [2*F-1:0] sqx_in, sqy_in;
   // Stage 2
   logic [F-1:0]  xf2_ff, yf2_ff, t3x2_ff, t3y2_ff;
   logic [F+4:0]  qx2_ff, qy2_ff;
   logic [2*F-1:0] cbx_in, cby_in;
   logic [F+5:0]  qx_in, qy_in;
   // Stage 3
   logic signed [NW-1:0] g00_3_ff, g10_3_ff, g01_3_ff, g11_3_ff;
   logic [F:0]  u3_ff, v3_ff;
   logic [2*F+4:0] fx_in, fy_in;
   logic signed [F+1:0] x0, x1, y0, y1;
   // Stage 4
   logic signed [NW:0]     d0, d1;
   logic signed [2*F+5:0]  m0_4_ff, m1_4_ff;
   logic signed [NW-1:0]   g00_4_ff, g01_4_ff;
   logic [F:0]             v4_ff;
   // Stage 5
   logic signed [NW-1:0]   l0_in, l1_in, l0_5_ff;
   logic signed [NW:0]     dl5_ff;
   logic [F:0]             v5_ff;
   // Stage 6
   logic signed [2*F+5:0]  m2_6_ff;
   logic signed [NW-1:0]   l0_6_ff;
   // Stage 7
   logic signed [NW-1:0]   noise_ff;

   assign xi = coord_x[fgnh_pkg::COORD_W-1:F];
   assign yi = coord_y[fgnh_pkg::COORD_W-1:F];
   assign xf = coord_x[F-1:0];
   assign yf = coord_y[F-1:0];

   // Corner column hashes
   fgnh_ram u_ram_a (
      .clock(clock), .wr_en(advance & ld.load), .wr_addr(ld.idx), .wr_data(ld.val),
      .rd_en(advance), .rd_addr0(xi), .rd_addr1(xi + 8'd1),
      .rd_data0(pa0), .rd_data1(pa1)
   );

   assign a_idx = pa0 + yi1_ff;
   assign b_idx = pa1 + yi1_ff;

   // Corner hashes, left and right columns
   fgnh_ram u_ram_b (
      .clock(clock), .wr_en(advance & ld1_ff.load), .wr_addr(ld1_ff.idx),
      .wr_data(ld1_ff.val), .rd_en(advance), .rd_addr0(a_idx),
      .rd_addr1(a_idx + 8'd1), .rd_data0(hb0), .rd_data1(hb1)
   );

   fgnh_ram u_ram_c (
      .clock(clock), .wr_en(advance & ld1_ff.load), .wr_addr(ld1_ff.idx),
      .wr_data(ld1_ff.val), .rd_en(advance), .rd_addr0(b_idx),
      .rd_addr1(b_idx + 8'd1), .rd_data0(hc0), .rd_data1(hc1)
   );

   // Fade and corner arithmetic
   always_comb begin
      sqx_in = (2*F)'(xf) * (2*F)'(xf);
      sqy_in = (2*F)'(yf) * (2*F)'(yf);
      cbx_in = (2*F)'(t2x1_ff) * (2*F)'(xf1_ff);
      cby_in = (2*F)'(t2y1_ff) * (2*F)'(yf1_ff);
      qx_in  = (F+6)'(10 << F) + (F+6)'(6) * (F+6)'(t2x1_ff) - (F+6)'(15) * (F+6)'(xf1_ff);
      qy_in  = (F+6)'(10 << F) + (F+6)'(6) * (F+6)'(t2y1_ff) - (F+6)'(15) * (F+6)'(yf1_ff);
      fx_in  = (2*F+5)'(t3x2_ff) * (2*F+5)'(qx2_ff);
      fy_in  = (2*F+5)'(t3y2_ff) * (2*F+5)'(qy2_ff);
      x0     = $signed({2'b00, xf2_ff});
      x1     = $signed({2'b11, xf2_ff});
      y0     = $signed({2'b00, yf2_ff});
      y1     = $signed({2'b11, yf2_ff});
      d0     = (NW+1)'(g10_3_ff) - (NW+1)'(g00_3_ff);
      d1     = (NW+1)'(g11_3_ff) - (NW+1)'(g01_3_ff);
      l0_in  = g00_4_ff + NW'(m0_4_ff >>> F);
      l1_in  = g01_4_ff + NW'(m1_4_ff >>> F);
   end

   // Hold table writes in step with stage 1 reads
   always_ff @(posedge clock) begin
      if (reset) begin
         ld1_ff.load <= 1'b0;
      end else if (advance) begin
         ld1_ff <= ld;
      end
   end

   // Advance the datapath
   always_ff @(posedge clock) begin
      if (advance) begin
         yi1_ff     <= yi;
         xf1_ff     <= xf;
         yf1_ff     <= yf;
         t2x1_ff    <= sqx_in[2*F-1:F];
         t2y1_ff    <= sqy_in[2*F-1:F];

         xf2_ff     <= xf1_ff;
         yf2_ff     <= yf1_ff;
         t3x2_ff    <= cbx_in[2*F-1:F];
         t3y2_ff    <= cby_in[2*F-1:F];
         qx2_ff     <= qx_in[F+4:0];
         qy2_ff     <= qy_in[F+4:0];

         g00_3_ff   <= fgnh_pkg::grad_fn(hb0[3:0], x0, y0);
         g10_3_ff   <= fgnh_pkg::grad_fn(hc0[3:0], x1, y0);
         g01_3_ff   <= fgnh_pkg::grad_fn(hb1[3:0], x0, y1);
         g11_3_ff   <= fgnh_pkg::grad_fn(hc1[3:0], x1, y1);
         u3_ff      <= fx_in[2*F:F];
         v3_ff      <= fy_in[2*F:F];

         m0_4_ff    <= $signed({1'b0, u3_ff}) * d0;
         m1_4_ff    <= $signed({1'b0, u3_ff}) * d1;
         g00_4_ff   <= g00_3_ff;
         g01_4_ff   <= g01_3_ff;
         v4_ff      <= v3_ff;

         l0_5_ff    <= l0_in;
         dl5_ff     <= (NW+1)'(l1_in) - (NW+1)'(l0_in);
         v5_ff      <= v4_ff;

         m2_6_ff    <= $signed({1'b0, v5_ff}) * dl5_ff;
         l0_6_ff    <= l0_5_ff;

         noise_ff   <= l0_6_ff + NW'(m2_6_ff >>> F);
      end
   end

   assign noise = noise_ff;

endmodule

### rtl/fractal_gradient_noise_height_top.sv
// Fractal gradient noise height generator, top level.
// Depends on fgnh_pkg, fgnh_octave, fgnh_ram and assert_macros.svh.
//
// Takes one item per cycle while req_tready is high. A load item (tuser
// low) writes one permutation entry into every table copy and gives no
// result; an evaluate item (tuser high) gives one result: the six-octave noise
// sum and the scaled, offset height clamped to 0..100. Each octave owns three
// dual-read copies of the table so all 36 lookups of a point happen in one
// pass; table writes flow down the pipeline beside evaluate items so every
// item sees exactly the writes accepted before it. An output register with a
// skid stage keeps input accepted while one result waits; tready drops only
// when both hold a result.
`include "assert_macros.svh"

module fractal_gradient_noise_height_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // perm_index, perm_value, coord_x, coord_y
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // noise_sum, height, zero fill
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int OCT = fgnh_pkg::OCTAVES;
   localparam int CW  = fgnh_pkg::COORD_W;
   localparam int NW  = fgnh_pkg::NOISE_W;
   localparam int SW  = fgnh_pkg::SUM_W;
   localparam int QW  = fgnh_pkg::NSUM_W;
   localparam int HW  = fgnh_pkg::HEIGHT_W;
   localparam int RW  = fgnh_pkg::REG_W;

   logic                 advance;
   logic [RW-1:0]        height_scale_ff;
   logic signed [RW-1:0] base_height_ff;

   logic                 s0_vld_ff;
   fgnh_pkg::action_type s0_act_ff;
   logic [7:0]           s0_idx_ff, s0_val_ff;
   logic [CW-1:0]        s0_cx_ff, s0_cy_ff;
   fgnh_pkg::load_type   s0_ld;

   logic [9:1]           eval_ff;
   logic signed [NW-1:0] oct_noise [OCT];
   logic signed [SW-1:0] sum_in, sum8_ff;
   logic signed [QW-1:0] sat_in, sat9_ff;
   logic signed [QW+RW:0] prod9_ff;
   logic signed [HW+4:0] hsum;
   logic [HW-1:0]        height_in;
   logic                 new_vld;

   logic                 rsp_vld_ff, skid_vld_ff;
   logic signed [QW-1:0] rsp_noise_ff, skid_noise_ff;
   logic [HW-1:0]        rsp_height_ff, skid_height_ff;

   assign advance    = !skid_vld_ff;
   assign req_tready = advance;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         height_scale_ff <= '0;
         base_height_ff  <= '0;
      end else if (csr_we) begin
         unique case (fgnh_pkg::csr_index_type'(csr_index))
            fgnh_pkg::CSR_HEIGHT_SCALE: height_scale_ff <= csr_wdata;
            fgnh_pkg::CSR_BASE_HEIGHT:  base_height_ff  <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // Capture the input item
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (advance) begin
         s0_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_act_ff <= fgnh_pkg::action_type'(req_tuser);
         s0_idx_ff <= req_tdata[7:0];
         s0_val_ff <= req_tdata[15:8];
         s0_cx_ff  <= req_tdata[39:16];
         s0_cy_ff  <= req_tdata[63:40];
      end
   end

   assign s0_ld.load = s0_vld_ff && (s0_act_ff == fgnh_pkg::ACT_LOAD);
   assign s0_ld.idx  = s0_idx_ff;
   assign s0_ld.val  = s0_val_ff;

   // One lane per octave, coordinates scaled by 2^o and wrapped
   for (genvar o = 0; o < OCT; o++) begin : g_oct
      fgnh_octave u_octave (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .ld      (s0_ld),
         .coord_x (CW'(s0_cx_ff << o)),
         .coord_y (CW'(s0_cy_ff << o)),
         .noise   (oct_noise[o])
      );
   end

   // Track evaluate items down the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         eval_ff <= '0;
      end else if (advance) begin
         eval_ff <= {eval_ff[8:1], s0_vld_ff && (s0_act_ff == fgnh_pkg::ACT_EVAL)};
      end
   end

   // Weight and sum octaves, saturate, scale, offset and clamp
   always_comb begin
      sum_in = '0;
      for (int o = 0; o < OCT; o++) begin
         sum_in = sum_in + (SW'(oct_noise[o]) >>> o);
      end
      if (sum8_ff > SW'((2 << fgnh_pkg::FRAC_BITS) - 1)) begin
         sat_in = {1'b0, {(QW-1){1'b1}}};
      end else if (sum8_ff < -SW'(2 << fgnh_pkg::FRAC_BITS)) begin
         sat_in = {1'b1, {(QW-1){1'b0}}};
      end else begin
         sat_in = sum8_ff[QW-1:0];
      end
      hsum = (HW+5)'(prod9_ff >>> 8)
           + ((HW+5)'(base_height_ff) <<< (fgnh_pkg::FRAC_BITS - 8));
      if (hsum < 0) begin
         height_in = '0;
      end else if (hsum > (HW+5)'(fgnh_pkg::HEIGHT_MAX)) begin
         height_in = fgnh_pkg::HEIGHT_MAX;
      end else begin
         height_in = hsum[HW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum8_ff  <= sum_in;
         sat9_ff  <= sat_in;
         prod9_ff <= sat_in * $signed({1'b0, height_scale_ff});
      end
   end

   assign new_vld = eval_ff[9] && advance;

   // Output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (rsp_vld_ff && !rsp_tready) begin
         if (new_vld) begin
            skid_vld_ff <= 1'b1;
         end
      end else if (skid_vld_ff) begin
         rsp_vld_ff  <= 1'b1;
         skid_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff  <= new_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_vld_ff && !rsp_tready) begin
         if (new_vld) begin
            skid_noise_ff  <= sat9_ff;
            skid_height_ff <= height_in;
         end
      end else if (skid_vld_ff) begin
         rsp_noise_ff  <= skid_noise_ff;
         rsp_height_ff <= skid_height_ff;
      end else begin
         rsp_noise_ff  <= sat9_ff;
         rsp_height_ff <= height_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {7'b0, rsp_height_ff, rsp_noise_ff};

   // A result waits in the skid stage only behind a held output
   `FGNH_ASSERT_IMPL(a_skid_behind_out, clock, reset, skid_vld_ff, rsp_vld_ff)
   // A delivered height never exceeds the clamp
   `FGNH_ASSERT_IMPL(a_height_range, clock, reset, rsp_vld_ff,
                     rsp_height_ff <= fgnh_pkg::HEIGHT_MAX)
   // A stalled pipeline keeps its items in place
   `FGNH_ASSERT_NEXT(a_stall_hold, clock, reset, !advance && !reset, $stable(eval_ff))

endmodule
